// ----- rtl/msb_first_bit_reader_top_macros.svh -----
// assertion macros for the msb-first bit reader checker
// expects clk_i and rst_ni in the scope of use
`ifndef MSB_FIRST_BIT_READER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_READER_TOP_MACROS_SVH

// clocked assertion, off while in reset
`define MSBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// assertion on a result beat that is being offered
`define MSBR_ASSERT_RESULT(label, prop, msg) \
  `MSBR_ASSERT(label, out_valid_i |-> (prop), msg)

`endif

// ----- rtl/msbr_pkg.sv -----
// shared constants, codes and types of the msb-first bit reader
// no dependencies
package msbr_pkg;

  localparam int unsigned BufferBits  = 64;
  localparam int unsigned MaxReadBits = 31;
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned AlignMask   = 7;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ValueW  = 31;
  localparam int unsigned StatusW = 2;

  localparam int unsigned HeldW = $clog2(BufferBits + 1);
  localparam int unsigned ReadW = $clog2(MaxReadBits + 1);

  // opcodes
  localparam logic [OpW-1:0] OP_PUSH  = 3'd0;
  localparam logic [OpW-1:0] OP_READ  = 3'd1;
  localparam logic [OpW-1:0] OP_SKIP  = 3'd2;
  localparam logic [OpW-1:0] OP_ALIGN = 3'd3;
  localparam logic [OpW-1:0] OP_END   = 3'd4;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK  = 2'd0;
  localparam logic [StatusW-1:0] ST_EOD = 2'd1;
  localparam logic [StatusW-1:0] ST_OVF = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD = 2'd3;

  // pending command
  typedef enum logic [2:0] {
    W_NONE = 3'b001,
    W_READ = 3'b010,
    W_SKIP = 3'b100
  } wait_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [ByteW-1:0]  byte_value;
    logic [CountW-1:0] bit_count;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [StatusW-1:0] status;
    logic [OpW-1:0]     done_op;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } core_out_t;

endpackage

// ----- rtl/msbr_if.sv -----
// valid/ready channel interfaces for command and result beats
// depends on msbr_pkg
interface msbr_in_if;
  import msbr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [ByteW-1:0]  byte_value;
  logic [CountW-1:0] bit_count;

  modport source (output valid, output opcode, output byte_value, output bit_count,
                  input ready);
  modport sink   (input valid, input opcode, input byte_value, input bit_count,
                  output ready);
endinterface

interface msbr_out_if;
  import msbr_pkg::*;

  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  value;
  logic [StatusW-1:0] status;
  logic [OpW-1:0]     done_op;

  modport source (output valid, output value, output status, output done_op,
                  input ready);
  modport sink   (input valid, input value, input status, input done_op,
                  output ready);
endinterface

// ----- rtl/msb_first_bit_reader_top.sv -----
// top level of the msb-first bit reader: input register, core, result register
// depends on msbr_pkg, msbr_if (msbr_in_if, msbr_out_if) and msbr_core
//
//  channel | dir | beat contents                     | handshake
//  --------+-----+-----------------------------------+-------------
//  in_i    | in  | opcode, byte_value, bit_count     | valid/ready
//  out_o   | out | value, status, done_op            | valid/ready
//
// one command or byte beat is taken every cycle while the result side is not stalled;
// any result it gives is offered after it passes the input register, then the result register
// the rate is set by the single pass through the buffer merge and barrel shift
// reset clears the bit buffer, the held count, any pending command and end flag
// a stalled result holds in its register; the input register keeps filling
// behind it and ready drops only when both are occupied
module msb_first_bit_reader_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  msbr_in_if.sink    in_i,
  msbr_out_if.source out_o
);
  import msbr_pkg::*;

  // input register
  logic      in_vld_q, in_vld_d;
  item_t     item_q;
  logic      in_take;

  // result register
  logic      out_vld_q, out_vld_d;
  result_t   res_q;

  // core
  logic      advance;
  core_out_t core_out;

  // the held beat moves on when the result register is free or being emptied
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && core_out.emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode     <= in_i.opcode;
      item_q.byte_value <= in_i.byte_value;
      item_q.bit_count  <= in_i.bit_count;
    end
    if (advance && core_out.emit) begin
      res_q <= core_out.res;
    end
  end

  // buffer state and decode of the held beat
  msbr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .out_o  (core_out)
  );

  assign out_o.valid   = out_vld_q;
  assign out_o.value   = res_q.value;
  assign out_o.status  = res_q.status;
  assign out_o.done_op = res_q.done_op;

endmodule

// ----- rtl/msbr_core.sv -----
// bit buffer state and single-pass command decode of the bit reader
// depends on msbr_pkg
module msbr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  msbr_pkg::item_t      item_i,
  output msbr_pkg::core_out_t  out_o
);
  import msbr_pkg::*;

  logic [BufferBits-1:0] buf_q, buf_d;
  logic [HeldW-1:0]      held_q, held_d;
  wait_e                 wait_q, wait_d;
  logic [CountW-1:0]     wcnt_q, wcnt_d;
  logic                  ended_q, ended_d;

  logic [HeldW:0]         held_ext;
  logic [HeldW:0]         held_plus;
  logic [BufferBits-1:0]  byte_top;
  logic [BufferBits-1:0]  merged;
  logic [BufferBits-1:0]  src_buf;
  logic [HeldW:0]         src_held;
  logic [HeldW:0]         drop;
  logic [ReadW-1:0]       take_n;
  logic                   use_take;
  logic [MaxReadBits-1:0] top_bits;
  logic [MaxReadBits-1:0] taken;
  logic [HeldW:0]         skip_n;
  logic [CountW-1:0]      remain;

  // decoded result fields
  logic                   emit_c;
  logic [ValueW-1:0]      value_c;
  logic [StatusW-1:0]     status_c;
  logic [OpW-1:0]         done_op_c;

  function automatic logic [HeldW:0] min_bits(logic [CountW-1:0] c, logic [HeldW:0] h);
    logic [HeldW:0] r;
    if (c < CountW'(h)) begin
      r = c[HeldW:0];
    end else begin
      r = h;
    end
    return r;
  endfunction

  assign held_ext  = {1'b0, held_q};
  assign held_plus = held_ext + (HeldW+1)'(ByteBits);
  assign byte_top  = {item_i.byte_value, {(BufferBits-ByteBits){1'b0}}};
  // new byte lands right behind the held bits, oldest bit at the top
  assign merged    = buf_q | (byte_top >> held_q);

  always_comb begin
    src_buf     = buf_q;
    src_held    = held_ext;
    drop        = '0;
    take_n      = '0;
    use_take    = 1'b0;
    skip_n      = '0;
    remain      = '0;
    wait_d      = wait_q;
    wcnt_d      = wcnt_q;
    ended_d     = ended_q;
    emit_c      = 1'b0;
    status_c    = ST_OK;
    done_op_c   = item_i.opcode;

    unique case (item_i.opcode)
      OP_PUSH: begin
        if (ended_q) begin
          emit_c   = 1'b1;
          status_c = ST_BAD;
        end else if (held_plus > (HeldW+1)'(BufferBits)) begin
          emit_c   = 1'b1;
          status_c = ST_OVF;
        end else begin
          src_buf  = merged;
          src_held = held_plus;
          if (wait_q == W_READ && CountW'(held_plus) >= wcnt_q) begin
            take_n    = wcnt_q[ReadW-1:0];
            drop      = (HeldW+1)'(take_n);
            use_take  = 1'b1;
            wait_d    = W_NONE;
            wcnt_d    = '0;
            emit_c    = 1'b1;
            done_op_c = OP_READ;
          end else if (wait_q == W_SKIP) begin
            skip_n = min_bits(wcnt_q, held_plus);
            drop   = skip_n;
            remain = wcnt_q - CountW'(skip_n);
            wcnt_d = remain;
            if (remain == '0) begin
              wait_d    = W_NONE;
              emit_c    = 1'b1;
              done_op_c = OP_SKIP;
            end
          end
        end
      end
      OP_READ: begin
        emit_c = 1'b1;
        if (wait_q != W_NONE || item_i.bit_count > CountW'(MaxReadBits)) begin
          status_c = ST_BAD;
        end else if (CountW'(held_ext) >= item_i.bit_count) begin
          take_n   = item_i.bit_count[ReadW-1:0];
          drop     = (HeldW+1)'(take_n);
          use_take = 1'b1;
        end else if (ended_q) begin
          status_c = ST_EOD;
        end else begin
          emit_c = 1'b0;
          wait_d = W_READ;
          wcnt_d = item_i.bit_count;
        end
      end
      OP_SKIP: begin
        emit_c = 1'b1;
        if (wait_q != W_NONE) begin
          status_c = ST_BAD;
        end else begin
          skip_n = min_bits(item_i.bit_count, held_ext);
          drop   = skip_n;
          remain = item_i.bit_count - CountW'(skip_n);
          if (remain == '0) begin
            status_c = ST_OK;
          end else if (ended_q) begin
            status_c = ST_EOD;
          end else begin
            emit_c = 1'b0;
            wait_d = W_SKIP;
            wcnt_d = remain;
          end
        end
      end
      OP_ALIGN: begin
        emit_c = 1'b1;
        if (wait_q != W_NONE) begin
          status_c = ST_BAD;
        end else begin
          drop = held_ext & (HeldW+1)'(AlignMask);
        end
      end
      OP_END: begin
        ended_d = 1'b1;
        if (wait_q != W_NONE) begin
          emit_c    = 1'b1;
          status_c  = ST_EOD;
          done_op_c = (wait_q == W_READ) ? OP_READ : OP_SKIP;
          wait_d    = W_NONE;
          wcnt_d    = '0;
        end
      end
      default: begin
        emit_c   = 1'b1;
        status_c = ST_BAD;
      end
    endcase
  end

  // first bits read come from the top of the buffer
  assign top_bits = src_buf[BufferBits-1 -: MaxReadBits];
  assign taken    = top_bits >> (ReadW'(MaxReadBits) - take_n);
  assign value_c  = use_take ? ValueW'(taken) : '0;

  assign out_o = {emit_c, value_c, status_c, done_op_c};

  assign buf_d  = src_buf << drop;
  assign held_d = HeldW'(src_held - drop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      held_q  <= '0;
      wait_q  <= W_NONE;
      wcnt_q  <= '0;
      ended_q <= 1'b0;
    end else if (fire_i) begin
      buf_q   <= buf_d;
      held_q  <= held_d;
      wait_q  <= wait_d;
      wcnt_q  <= wcnt_d;
      ended_q <= ended_d;
    end
  end

endmodule

// ----- rtl/msbr_checker.sv -----
// port-level checks on the bit reader result channel, bound to the top level
// depends on msbr_pkg and msb_first_bit_reader_top_macros.svh
`include "msb_first_bit_reader_top_macros.svh"

module msbr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [msbr_pkg::ValueW-1:0]   out_value_i,
  input logic [msbr_pkg::StatusW-1:0]  out_status_i,
  input logic [msbr_pkg::OpW-1:0]      out_done_op_i
);
  import msbr_pkg::*;

  // a stalled result beat stays put
  `MSBR_ASSERT(a_result_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_status_i) && $stable(out_done_op_i), "result beat changed while stalled")

  // only a successful read carries bits
  `MSBR_ASSERT_RESULT(a_value_read, out_value_i == '0 || (out_status_i == ST_OK && out_done_op_i == OP_READ), "nonzero value on a result that is not a good read")

  // a push only reports a dropped byte
  `MSBR_ASSERT_RESULT(a_push_status, out_done_op_i != OP_PUSH || out_status_i == ST_OVF || out_status_i == ST_BAD, "push result with ok or end of data status")

  // end of data only ends a read or a skip
  `MSBR_ASSERT_RESULT(a_eod_op, out_status_i != ST_EOD || out_done_op_i == OP_READ || out_done_op_i == OP_SKIP, "end of data reported on wrong command")

endmodule

bind msb_first_bit_reader_top msbr_checker u_msbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_value_i   (out_o.value),
  .out_status_i  (out_o.status),
  .out_done_op_i (out_o.done_op)
);
